/* rtl/rmsc_pkg.sv */
// rmsc_pkg: shared types and codes of the rule match specificity classifier
// used by the sequencer, the top level, the checker and the testbench, depends on nothing
package rmsc_pkg;

   localparam logic OP_WRITE    = 1'b0;
   localparam logic OP_CLASSIFY = 1'b1;

   localparam logic [1:0] PRED_ZERO = 2'd0;
   localparam logic [1:0] PRED_ONE  = 2'd1;
   localparam logic [1:0] PRED_NONE = 2'd2;

   typedef struct packed {
      logic        opcode;
      logic [5:0]  rule_slot;
      logic [31:0] rule_care;
      logic [31:0] rule_required;
      logic        rule_label;
      logic        rule_enable;
      logic [31:0] instance_present;
      logic [31:0] instance_bits;
   } rmsc_req_type;

   typedef struct packed {
      logic [1:0] prediction;
      logic [6:0] applicable_count;
      logic [6:0] maximal_count;
   } rmsc_rsp_type;

   // top level to sequencer
   typedef struct packed {
      logic        start;
      logic        classify;
      logic        take;
      logic [31:0] present;
      logic [31:0] bits;
   } rmsc_ctl_type;

   // sequencer to top level
   typedef struct packed {
      logic busy;
      logic done;
   } rmsc_stat_type;

endpackage

/* rtl/rmsc_ram.sv */
// rmsc_ram: generic single write port ram with one registered read port
// no dependencies
module rmsc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/rmsc_rule_store.sv */
// rmsc_rule_store: rule table, a full rule ram plus a second ram copy of the care masks, plus the enable bits
// depends on rmsc_ram
module rmsc_rule_store #(
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [31:0]              wr_care,
   input  logic [31:0]              wr_required,
   input  logic                     wr_label,
   input  logic                     wr_enable,
   input  logic [$clog2(DEPTH)-1:0] a_addr,
   output logic [31:0]              a_care,
   output logic [31:0]              a_required,
   output logic                     a_label,
   output logic                     a_enable,
   input  logic [$clog2(DEPTH)-1:0] b_addr,
   output logic [31:0]              b_care
);

   logic [DEPTH-1:0] enable_ff;
   logic [DEPTH-1:0] enable_in;
   logic             a_enable_ff;
   logic [64:0]      a_word;

   // port a serves the scan and the candidate rule, port b the inner sweep
   rmsc_ram #(.WIDTH(65), .DEPTH(DEPTH)) u_rule_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data ({wr_label, wr_required, wr_care}),
      .rd_addr (a_addr),
      .rd_data (a_word)
   );

   rmsc_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_care_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_care),
      .rd_addr (b_addr),
      .rd_data (b_care)
   );

   always_comb begin
      enable_in = enable_ff;
      if (wr_en) begin
         enable_in[wr_addr] = wr_enable;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= '0;
      end else begin
         enable_ff <= enable_in;
      end
      a_enable_ff <= enable_ff[a_addr];
   end

   assign a_care     = a_word[31:0];
   assign a_required = a_word[63:32];
   assign a_label    = a_word[64];
   assign a_enable   = a_enable_ff;

endmodule

/* rtl/rmsc_sequencer.sv */
// rmsc_sequencer: applicability scan and pairwise containment sweep
// depends on rmsc_pkg, reads the table through rmsc_rule_store
module rmsc_sequencer import rmsc_pkg::*; #(
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     reset,
   input  rmsc_ctl_type             ctl,
   output rmsc_stat_type            stat,
   output rmsc_rsp_type             result,
   output logic [$clog2(DEPTH)-1:0] a_addr,
   input  logic [31:0]              a_care,
   input  logic [31:0]              a_required,
   input  logic                     a_label,
   input  logic                     a_enable,
   output logic [$clog2(DEPTH)-1:0] b_addr,
   input  logic [31:0]              b_care
);

   localparam int AW = $clog2(DEPTH);
   localparam logic [AW:0] LAST = (AW+1)'(DEPTH);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_SCAN  = 3'd1;
   localparam logic [2:0] S_ISEL  = 3'd2;
   localparam logic [2:0] S_ILOAD = 3'd3;
   localparam logic [2:0] S_INNER = 3'd4;
   localparam logic [2:0] S_DONE  = 3'd5;

   logic [2:0]       state_ff, state_in;
   logic [AW:0]      k_ff, k_in;
   logic [AW-1:0]    idx_ff, idx_in;
   logic             vld_ff, vld_in;
   logic [AW:0]      i_ff, i_in;
   logic [DEPTH-1:0] hit_ff, hit_in;
   logic [6:0]       napp_ff, napp_in;
   logic [6:0]       nmax_ff, nmax_in;
   logic             seen_ff, seen_in;
   logic             lab_ff, lab_in;
   logic             mixed_ff, mixed_in;
   logic [31:0]      ci_ff, ci_in;
   logic             li_ff, li_in;
   logic [31:0]      present_ff, present_in;
   logic [31:0]      bits_ff, bits_in;

   logic issue;
   logic scan_hit;
   logic covered_now;

   assign issue    = k_ff < LAST;
   assign a_addr   = (state_ff == S_SCAN) ? k_ff[AW-1:0] : i_ff[AW-1:0];
   assign b_addr   = k_ff[AW-1:0];
   assign scan_hit = a_enable && ((a_care & ~present_ff) == 32'd0)
                     && (((a_required ^ bits_ff) & a_care) == 32'd0);
   // both rules agree with the instance, so only the care masks matter
   assign covered_now = vld_ff && hit_ff[idx_ff] && (idx_ff != i_ff[AW-1:0])
                        && ((ci_ff & ~b_care) == 32'd0) && (ci_ff != b_care);

   always_comb begin
      state_in   = state_ff;
      k_in       = k_ff;
      idx_in     = idx_ff;
      vld_in     = vld_ff;
      i_in       = i_ff;
      hit_in     = hit_ff;
      napp_in    = napp_ff;
      nmax_in    = nmax_ff;
      seen_in    = seen_ff;
      lab_in     = lab_ff;
      mixed_in   = mixed_ff;
      ci_in      = ci_ff;
      li_in      = li_ff;
      present_in = present_ff;
      bits_in    = bits_ff;
      case (state_ff)
         S_IDLE: begin
            if (ctl.start) begin
               napp_in  = '0;
               nmax_in  = '0;
               seen_in  = 1'b0;
               lab_in   = 1'b0;
               mixed_in = 1'b0;
               if (ctl.classify) begin
                  present_in = ctl.present;
                  bits_in    = ctl.bits;
                  k_in       = '0;
                  vld_in     = 1'b0;
                  hit_in     = '0;
                  state_in   = S_SCAN;
               end else begin
                  state_in = S_DONE;
               end
            end
         end
         S_SCAN: begin
            vld_in = issue;
            if (issue) begin
               k_in   = k_ff + 1'b1;
               idx_in = k_ff[AW-1:0];
            end
            if (vld_ff) begin
               hit_in[idx_ff] = scan_hit;
               if (scan_hit) begin
                  napp_in = napp_ff + 7'd1;
               end
            end
            if (!issue) begin
               i_in     = '0;
               state_in = S_ISEL;
            end
         end
         S_ISEL: begin
            if (i_ff == LAST) begin
               state_in = S_DONE;
            end else if (hit_ff[i_ff[AW-1:0]]) begin
               state_in = S_ILOAD;
            end else begin
               i_in = i_ff + 1'b1;
            end
         end
         S_ILOAD: begin
            ci_in    = a_care;
            li_in    = a_label;
            k_in     = '0;
            vld_in   = 1'b0;
            state_in = S_INNER;
         end
         S_INNER: begin
            vld_in = issue;
            if (issue) begin
               k_in   = k_ff + 1'b1;
               idx_in = k_ff[AW-1:0];
            end
            if (covered_now) begin
               i_in     = i_ff + 1'b1;
               state_in = S_ISEL;
            end else if (!issue) begin
               // swept every rule without finding a strict superset
               nmax_in = nmax_ff + 7'd1;
               if (!seen_ff) begin
                  seen_in = 1'b1;
                  lab_in  = li_ff;
               end else if (li_ff != lab_ff) begin
                  mixed_in = 1'b1;
               end
               i_in     = i_ff + 1'b1;
               state_in = S_ISEL;
            end
         end
         S_DONE: begin
            if (ctl.take) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      k_ff       <= k_in;
      idx_ff     <= idx_in;
      vld_ff     <= vld_in;
      i_ff       <= i_in;
      hit_ff     <= hit_in;
      napp_ff    <= napp_in;
      nmax_ff    <= nmax_in;
      seen_ff    <= seen_in;
      lab_ff     <= lab_in;
      mixed_ff   <= mixed_in;
      ci_ff      <= ci_in;
      li_ff      <= li_in;
      present_ff <= present_in;
      bits_ff    <= bits_in;
   end

   assign stat.busy = (state_ff != S_IDLE);
   assign stat.done = (state_ff == S_DONE);

   assign result.prediction       = (!seen_ff || mixed_ff) ? PRED_NONE
                                    : (lab_ff ? PRED_ONE : PRED_ZERO);
   assign result.applicable_count = napp_ff;
   assign result.maximal_count    = nmax_ff;

endmodule

/* rtl/rule_match_specificity_classifier.sv */
// a write word finishes without any scan; a classify word first scans every entry for
// applicability, then for each applicable rule loads it and sweeps all entries for a strict
// superset, leaving the sweep early once one is found; non-applicable rules are skipped, and
// each ram has one read port
// throughput: one word at a time; a new word is taken once the result sits in the output reg
// reset: enable bits clear at once, rule contents stay undefined until written, no sweep
module rule_match_specificity_classifier import rmsc_pkg::*; #(
   parameter int RULES    = 64,
   parameter int FEATURES = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  rmsc_req_type req_word,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rmsc_rsp_type rsp_word
);

   // the slot field addresses 64 entries at most
   localparam int DEPTH = (RULES < 64) ? RULES : 64;
   localparam int AW    = $clog2(DEPTH);
   localparam int EFF   = (FEATURES < 32) ? FEATURES : 32;
   localparam logic [31:0] FMASK = (EFF >= 32) ? 32'hFFFF_FFFF
                                   : ((32'd1 << EFF) - 32'd1);

   rmsc_ctl_type  ctl;
   rmsc_stat_type stat;
   rmsc_rsp_type  result;

   logic          accept;
   logic          wr_en;
   logic [AW-1:0] a_addr, b_addr;
   logic [31:0]   a_care, a_required, b_care;
   logic          a_label, a_enable;
   logic          rsp_valid_ff, rsp_valid_in;
   rmsc_rsp_type  rsp_word_ff, rsp_word_in;

   assign req_stall = stat.busy;
   assign accept    = req_valid && !req_stall;
   assign wr_en     = accept && (req_word.opcode == OP_WRITE)
                      && (32'(req_word.rule_slot) < DEPTH);

   assign ctl.start    = accept;
   assign ctl.classify = (req_word.opcode == OP_CLASSIFY);
   assign ctl.present  = req_word.instance_present & FMASK;
   assign ctl.bits     = req_word.instance_bits & FMASK;
   assign ctl.take     = stat.done && (!rsp_valid_ff || !rsp_stall);

   rmsc_rule_store #(.DEPTH(DEPTH)) u_store (
      .clock       (clock),
      .reset       (reset),
      .wr_en       (wr_en),
      .wr_addr     (req_word.rule_slot[AW-1:0]),
      .wr_care     (req_word.rule_care & FMASK),
      .wr_required (req_word.rule_required & FMASK),
      .wr_label    (req_word.rule_label),
      .wr_enable   (req_word.rule_enable),
      .a_addr      (a_addr),
      .a_care      (a_care),
      .a_required  (a_required),
      .a_label     (a_label),
      .a_enable    (a_enable),
      .b_addr      (b_addr),
      .b_care      (b_care)
   );

   rmsc_sequencer #(.DEPTH(DEPTH)) u_seq (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl),
      .stat       (stat),
      .result     (result),
      .a_addr     (a_addr),
      .a_care     (a_care),
      .a_required (a_required),
      .a_label    (a_label),
      .a_enable   (a_enable),
      .b_addr     (b_addr),
      .b_care     (b_care)
   );

   always_comb begin
      rsp_word_in = rsp_word_ff;
      if (ctl.take) begin
         rsp_valid_in = 1'b1;
         rsp_word_in  = result;
      end else if (rsp_stall) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

/* rtl/rmsc_checker.sv */
// rmsc_checker: port level assertions of the classifier, bound to the top level
// depends on rmsc_pkg and rule_match_specificity_classifier
module rmsc_checker import rmsc_pkg::*; (
   input logic         clock,
   input logic         reset,
   input logic         req_valid,
   input logic         req_stall,
   input rmsc_req_type req_word,
   input logic         rsp_valid,
   input logic         rsp_stall,
   input rmsc_rsp_type rsp_word
);

   // a stalled result word holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word))
      else $error("stalled result word changed");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_word.maximal_count <= rsp_word.applicable_count)
      else $error("more maximal rules than applicable rules");

   // no kept rule means nothing to predict
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_word.maximal_count == 7'd0)
      |-> rsp_word.prediction == PRED_NONE)
      else $error("prediction without any maximal rule");

   // the block works on one word at a time
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second word taken before the first was finished");

endmodule

bind rule_match_specificity_classifier rmsc_checker u_checker (.*);

/* tb/testbench.sv */
// testbench for rule_match_specificity_classifier: directed write and classify words, then
// random ones, each result checked against its listed expectation or an in-bench predictor
// depends on rmsc_pkg and the rtl of the block
module testbench;
   import rmsc_pkg::*;

   localparam int RULE_COUNT = 64;
   // features that most random rules draw their conditions from, so containment is common
   localparam logic [31:0] HOT_FEATURES = 32'h8030_0c0f;

   typedef struct packed {
      logic         typed;
      rmsc_rsp_type want;
      rmsc_req_type w;
   } plan_row_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   rmsc_req_type req_word = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rmsc_rsp_type rsp_word;

   // predictor copy of the rule table
   logic [31:0] care_mem [RULE_COUNT];
   logic [31:0] need_mem [RULE_COUNT];
   logic        label_mem [RULE_COUNT];
   logic        en_mem [RULE_COUNT];

   rmsc_rsp_type pending_outcomes [$];
   plan_row_type directed_rows [$];

   int send_idle_pct = 31;
   int recv_idle_pct = 50;
   int err_count = 0;
   int n_write = 0;
   int n_classify = 0;
   int n_abstain = 0;
   int peak_fit = 0;
   logic [31:0] truth;

   rule_match_specificity_classifier #(
      .RULES(RULE_COUNT),
      .FEATURES(32)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_word(req_word),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_word(rsp_word)
   );

   always #10 clock = ~clock;

   function automatic rmsc_req_type wr_word(input logic [5:0] slot, input logic [31:0] care,
                                            input logic [31:0] need, input logic lab,
                                            input logic en);
      rmsc_req_type w;
      w = '0;
      w.opcode = OP_WRITE;
      w.rule_slot = slot;
      w.rule_care = care;
      w.rule_required = need;
      w.rule_label = lab;
      w.rule_enable = en;
      return w;
   endfunction

   function automatic rmsc_req_type cl_word(input logic [31:0] present, input logic [31:0] val);
      rmsc_req_type w;
      w = '0;
      w.opcode = OP_CLASSIFY;
      w.instance_present = present;
      w.instance_bits = val;
      return w;
   endfunction

   function automatic rmsc_rsp_type outcome(input logic [1:0] pred, input int n_app,
                                            input int n_max);
      rmsc_rsp_type r;
      r.prediction = pred;
      r.applicable_count = n_app[6:0];
      r.maximal_count = n_max[6:0];
      return r;
   endfunction

   // applies a word to the predictor table and returns the result it should give
   function automatic rmsc_rsp_type rule_outcome(input rmsc_req_type w);
      rmsc_rsp_type r;
      logic [RULE_COUNT-1:0] fits;
      int i, j, n_fit, n_top;
      logic first_lab;
      logic seen, split, covered;
      r = outcome(PRED_NONE, 0, 0);
      if (w.opcode == OP_WRITE) begin
         care_mem[w.rule_slot] = w.rule_care;
         need_mem[w.rule_slot] = w.rule_required;
         label_mem[w.rule_slot] = w.rule_label;
         en_mem[w.rule_slot] = w.rule_enable;
         return r;
      end
      fits = '0;
      n_fit = 0;
      for (i = 0; i < RULE_COUNT; i++) begin
         if (en_mem[i]) begin
            if ((care_mem[i] & ~w.instance_present) == '0 &&
                ((need_mem[i] ^ w.instance_bits) & care_mem[i]) == '0) begin
               fits[i] = 1'b1;
               n_fit++;
            end
         end
      end
      n_top = 0;
      seen = 1'b0;
      split = 1'b0;
      first_lab = 1'b0;
      for (i = 0; i < RULE_COUNT; i++) begin
         if (fits[i]) begin
            covered = 1'b0;
            for (j = 0; j < RULE_COUNT; j++) begin
               if (j != i && fits[j] && (care_mem[i] & ~care_mem[j]) == '0 &&
                   care_mem[i] != care_mem[j])
                  covered = 1'b1;
            end
            if (!covered) begin
               n_top++;
               if (!seen) begin
                  first_lab = label_mem[i];
                  seen = 1'b1;
               end else if (label_mem[i] != first_lab) begin
                  split = 1'b1;
               end
            end
         end
      end
      if (seen && !split)
         r.prediction = first_lab ? PRED_ONE : PRED_ZERO;
      r.applicable_count = n_fit[6:0];
      r.maximal_count = n_top[6:0];
      return r;
   endfunction

   task automatic add_row(input logic typed, input rmsc_rsp_type want, input rmsc_req_type w);
      directed_rows.push_back({typed, want, w});
   endtask

   // offers one word, keeps valid high across back-to-back words
   task automatic send_word(input rmsc_req_type w, input logic typed, input rmsc_rsp_type want);
      rmsc_rsp_type pred;
      if ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_word <= w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pred = rule_outcome(w);
      pending_outcomes.push_back(typed ? want : pred);
      if (w.opcode == OP_CLASSIFY) begin
         n_classify++;
         if (pred.prediction == PRED_NONE) n_abstain++;
         if (pred.applicable_count > peak_fit) peak_fit = pred.applicable_count;
      end else begin
         n_write++;
      end
   endtask

   task automatic run_random(input int count);
      rmsc_req_type w;
      logic [31:0] care, need, present, val;
      logic [5:0] slot;
      int k, pick;
      for (k = 0; k < count; k++) begin
         if ($urandom_range(0, 99) < 35) begin
            pick = $urandom_range(0, 9);
            if (pick == 0) care = '0;
            else if (pick <= 7) care = $urandom & HOT_FEATURES;
            else care = $urandom;
            need = (truth & care) | ($urandom & ~care);
            // now and then a rule that disagrees with the usual instance
            if ($urandom_range(0, 7) == 0) need = need ^ (care & $urandom);
            if ($urandom_range(0, 3) == 0) slot = 6'($urandom_range(0, 63));
            else slot = 6'($urandom_range(0, 11));
            w = wr_word(slot, care, need, 1'($urandom_range(0, 1)),
                        $urandom_range(0, 99) < 85);
         end else begin
            pick = $urandom_range(0, 9);
            if (pick == 0) begin
               present = $urandom;
               val = $urandom;
            end else begin
               present = '1;
               if (pick >= 6) present = present & ~(HOT_FEATURES & $urandom & $urandom);
               val = (truth & present) | ($urandom & ~present);
               if (pick == 9) val = val ^ (HOT_FEATURES & $urandom & $urandom);
            end
            w = cl_word(present, val);
         end
         send_word(w, 1'b0, '0);
      end
   endtask

   // result side: random stall, compare each taken word with the oldest expectation
   always @(posedge clock) begin
      rmsc_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_outcomes.size() == 0) begin
            $display("%0t: unexpected result word %h", $time, rsp_word);
            err_count++;
         end else begin
            want = pending_outcomes.pop_front();
            if (rsp_word.prediction !== want.prediction) begin
               $display("%0t: prediction expected %0d got %0d", $time,
                        want.prediction, rsp_word.prediction);
               err_count++;
            end
            if (rsp_word.applicable_count !== want.applicable_count) begin
               $display("%0t: applicable_count expected %0d got %0d", $time,
                        want.applicable_count, rsp_word.applicable_count);
               err_count++;
            end
            if (rsp_word.maximal_count !== want.maximal_count) begin
               $display("%0t: maximal_count expected %0d got %0d", $time,
                        want.maximal_count, rsp_word.maximal_count);
               err_count++;
            end
         end
      end
      rsp_stall <= (recv_idle_pct != 0) && ($urandom_range(0, 99) < recv_idle_pct);
   end

   initial begin
      rmsc_rsp_type quiet;
      int i;
      quiet = outcome(PRED_NONE, 0, 0);
      for (i = 0; i < RULE_COUNT; i++) begin
         care_mem[i] = '0;
         need_mem[i] = '0;
         label_mem[i] = 1'b0;
         en_mem[i] = 1'b0;
      end

      // empty table, empty rule, full rule, equal rules with split and shared labels,
      // disabled entries, required bits outside the care mask
      add_row(1'b1, quiet, cl_word('1, '1));
      add_row(1'b1, quiet, wr_word(6'd0, '0, '1, 1'b1, 1'b1));
      add_row(1'b1, outcome(PRED_ONE, 1, 1), cl_word('0, '0));
      add_row(1'b1, quiet, wr_word(6'd63, '1, '1, 1'b0, 1'b1));
      add_row(1'b1, outcome(PRED_ZERO, 2, 1), cl_word('1, '1));
      add_row(1'b1, outcome(PRED_ONE, 1, 1), cl_word('1, 32'hffff_fffe));
      add_row(1'b1, outcome(PRED_ONE, 1, 1), cl_word(32'h7fff_ffff, '1));
      add_row(1'b1, quiet, wr_word(6'd5, 32'h0000_00f0, 32'hffff_ff3f, 1'b1, 1'b1));
      add_row(1'b1, quiet, wr_word(6'd6, 32'h0000_00f0, 32'h0000_0030, 1'b0, 1'b1));
      add_row(1'b0, quiet, cl_word(32'h0000_00ff, 32'h0000_0030));
      add_row(1'b1, quiet, wr_word(6'd6, 32'h0000_00f0, 32'h0000_0030, 1'b1, 1'b1));
      add_row(1'b0, quiet, cl_word(32'h0000_00ff, 32'hffff_ff30));
      add_row(1'b1, quiet, wr_word(6'd7, 32'h0000_0010, 32'h0000_0010, 1'b0, 1'b0));
      add_row(1'b0, quiet, cl_word(32'h0000_00ff, 32'h0000_0030));
      add_row(1'b1, quiet, wr_word(6'd7, 32'h0000_0010, 32'h0000_0010, 1'b0, 1'b1));
      add_row(1'b0, quiet, cl_word(32'h0000_00ff, 32'h0000_0030));
      add_row(1'b0, quiet, cl_word(32'h0000_00ff, 32'h0000_0020));
      add_row(1'b1, quiet, wr_word(6'd0, '0, '0, 1'b1, 1'b0));
      add_row(1'b1, quiet, cl_word('0, '0));
      add_row(1'b1, quiet, wr_word(6'd62, 32'h8000_0000, '0, 1'b1, 1'b1));
      add_row(1'b0, quiet, cl_word('1, 32'h7fff_ffff));
      add_row(1'b1, quiet, wr_word(6'd63, '1, '1, 1'b0, 1'b0));

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      for (i = 0; i < directed_rows.size(); i++)
         send_word(directed_rows[i].w, directed_rows[i].typed, directed_rows[i].want);

      truth = $urandom;
      run_random(40);
      send_idle_pct = 50;
      recv_idle_pct = 31;
      run_random(40);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      run_random(38);
      req_valid <= 1'b0;

      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);

      $display("covered %0d rule writes and %0d classifications, %0d of them abstaining",
               n_write, n_classify, n_abstain);
      $display("at most %0d rules applied to one instance", peak_fit);
      if (err_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   initial begin
      #80000000;
      $display("simulation failed");
      $finish;
   end

endmodule

/* sim.f */
rtl/rmsc_pkg.sv
rtl/rmsc_ram.sv
rtl/rmsc_rule_store.sv
rtl/rmsc_sequencer.sv
rtl/rule_match_specificity_classifier.sv
rtl/rmsc_checker.sv
tb/testbench.sv
